/* hdl/thct_pkg.sv */
// Package for the token hash count table: field widths, status codes and FNV constants.
// No dependencies. Used by every file of the block.
package thct_pkg;
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_TOO_LONG  = 2'd3
    } status_t;

    typedef enum logic
    {
        MODE_INSERT = 1'b0,
        MODE_LOOKUP = 1'b1
    } mode_t;

    typedef struct packed {
        logic [11:0] entry_id;
        logic        is_new;
        logic        is_label;
        logic [31:0] entry_count;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        logic        mode;
        logic [7:0]  token_byte;
        logic        last_byte;
    } in_t;
endpackage

/* hdl/thct_if.sv */
// Valid/ready channel interfaces for the token hash count table.
// Depends on thct_pkg for the payload types.
interface thct_in_if
    import thct_pkg::*;
();
    logic valid;
    logic ready;
    logic mode;
    logic [7:0] token_byte;
    logic last_byte;
    modport source (output valid, mode, token_byte, last_byte, input ready);
    modport sink (input valid, mode, token_byte, last_byte, output ready);
endinterface

interface thct_out_if
    import thct_pkg::*;
();
    logic valid;
    logic ready;
    logic [11:0] entry_id;
    logic is_new;
    logic is_label;
    logic [31:0] entry_count;
    logic [1:0] status;
    modport source (output valid, entry_id, is_new, is_label, entry_count, status,
                    input ready);
    modport sink (input valid, entry_id, is_new, is_label, entry_count, status,
                  output ready);
endinterface

/* hdl/thct_fifo.sv */
// Short queue of byte beats between the front and the back part.
// Depends on thct_pkg for the beat type.
module thct_fifo
    import thct_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  in_t  wr_data,
    output logic full,
    input  logic rd_en,
    output in_t  rd_data,
    output logic empty
);
    in_t        mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign full    = cnt_reg == 3'd4;
    assign empty   = cnt_reg == 3'd0;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= wp_reg + 2'd1;
            end
            if (rd_en)
            begin
                rp_reg <= rp_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + {2'd0, wr_en} - {2'd0, rd_en};
        end
    end
endmodule

/* hdl/thct_back.sv */
// Back part: hashes the bytes, buffers the token, probes and updates the table.
// Depends on thct_pkg. Holds the slot, symbol, length, count and type memories.
module thct_back
    import thct_pkg::*;
#(
    parameter int TABLE_SIZE    = 4096,
    parameter int MAX_TOKEN_LEN = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [63:0] label_prefix,
    input  logic [3:0]  label_prefix_len,
    input  logic        beat_valid,
    input  in_t         beat,
    output logic        beat_take,
    output logic        res_valid,
    output result_t     res,
    input  logic        res_ready
);
    localparam int AW = $clog2(TABLE_SIZE);
    localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
    localparam int BW = $clog2(MAX_TOKEN_LEN);
    localparam int SD = TABLE_SIZE * (2 ** BW);

    typedef enum logic [7:0] {
        S_BYTE  = 8'b00000001,
        S_CLEAR = 8'b00000010,
        S_SLOT  = 8'b00000100,
        S_CHK   = 8'b00001000,
        S_LEN   = 8'b00010000,
        S_CMP   = 8'b00100000,
        S_DONE  = 8'b01000000,
        S_WRITE = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    // Each slot holds the entry id plus one, zero for an empty slot. A sweep after
    // reset writes zero to one slot per cycle until every slot is clear.
    logic [AW:0]   slot_mem [TABLE_SIZE];
    logic [7:0]    sym_mem  [SD];
    logic [LW-1:0] len_mem  [TABLE_SIZE];
    logic [31:0]   cnt_mem  [TABLE_SIZE];
    logic          typ_mem  [TABLE_SIZE];

    logic [7:0]    tok_reg [MAX_TOKEN_LEN];
    logic [31:0]   hash_reg, hx_reg;
    logic          mul_pend_reg;
    logic [LW-1:0] len_reg;
    logic          over_reg, pmatch_reg, mode_reg, label_reg;
    logic          found_reg, empty_reg;
    logic [AW:0]   clr_reg;
    logic [AW-1:0] pos_reg;
    logic [AW:0]   visits_reg;
    logic [AW:0]   used_reg;
    logic [39:0]   seen_reg;
    logic [AW-1:0] sid_reg;
    logic [BW:0]   ci_reg;
    logic [AW:0]   slot_rd_reg;
    logic [LW-1:0] len_rd_reg;
    logic [7:0]    sym_rd_reg;
    logic [31:0]   cnt_rd_reg;
    logic          typ_rd_reg;
    logic          rv_reg;
    result_t       res_reg;
    logic [31:0]   prod;
    logic [3:0]    plen;
    logic [7:0]    pb;
    logic [AW-1:0] pos_inc;
    logic [BW:0]   cmp_idx;
    logic [BW:0]   tail_idx;
    logic          mismatch, last_cmp, last_wr, probe_end;
    logic          out_free, done_go, do_new, do_inc;
    logic [31:0]   cnt_inc;

    assign plen    = label_prefix_len > 4'd8 ? 4'd8 : label_prefix_len;
    assign pb      = label_prefix[{len_reg[2:0], 3'b000} +: 8];
    assign prod    = hx_reg * FNV_PRIME;
    assign pos_inc = (pos_reg == AW'(TABLE_SIZE - 1)) ? '0 : pos_reg + 1'b1;

    // The stored byte in sym_rd_reg belongs to the index one below ci_reg.
    assign cmp_idx   = ci_reg - 1'b1;
    assign tail_idx  = (BW+1)'(len_reg - 1'b1);
    assign mismatch  = (len_rd_reg != len_reg) || (sym_rd_reg != tok_reg[cmp_idx[BW-1:0]]);
    assign last_cmp  = cmp_idx == tail_idx;
    assign last_wr   = ci_reg == tail_idx;
    assign probe_end = visits_reg == (AW+1)'(TABLE_SIZE - 1);

    assign out_free = !rv_reg || res_ready;
    assign done_go  = (state_reg == S_DONE) && out_free;
    assign do_new   = done_go && !over_reg && !found_reg && empty_reg
                      && (mode_reg == MODE_INSERT) && (used_reg < (AW+1)'(TABLE_SIZE));
    assign do_inc   = done_go && !over_reg && found_reg && (mode_reg == MODE_INSERT)
                      && (cnt_rd_reg != 32'hFFFF_FFFF);
    assign cnt_inc  = (cnt_rd_reg == 32'hFFFF_FFFF) ? cnt_rd_reg : cnt_rd_reg + 32'd1;

    assign res_valid = rv_reg;
    assign res       = res_reg;
    assign beat_take = (state_reg == S_BYTE) && beat_valid && !mul_pend_reg && clr_reg[AW];

    // Memory reads are registered.
    always_ff @(posedge clk)
    begin
        slot_rd_reg <= slot_mem[pos_reg];
        len_rd_reg  <= len_mem[sid_reg];
        sym_rd_reg  <= sym_mem[{sid_reg, ci_reg[BW-1:0]}];
        cnt_rd_reg  <= cnt_mem[sid_reg];
        typ_rd_reg  <= typ_mem[sid_reg];
        if (!clr_reg[AW])
        begin
            slot_mem[clr_reg[AW-1:0]] <= '0;
        end
        else if (do_new)
        begin
            slot_mem[pos_reg] <= used_reg + 1'b1;
        end
        if (do_new)
        begin
            len_mem[used_reg[AW-1:0]] <= len_reg;
            cnt_mem[used_reg[AW-1:0]] <= 32'd1;
            typ_mem[used_reg[AW-1:0]] <= label_reg;
        end
        else if (do_inc)
        begin
            cnt_mem[sid_reg] <= cnt_inc;
        end
        if (state_reg == S_WRITE)
        begin
            sym_mem[{sid_reg, ci_reg[BW-1:0]}] <= tok_reg[ci_reg[BW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_take && len_reg < LW'(MAX_TOKEN_LEN))
        begin
            tok_reg[len_reg[BW-1:0]] <= beat.token_byte;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_BYTE:  if (beat_take && beat.last_byte) state_next = S_CLEAR;
            S_CLEAR: state_next = over_reg ? S_DONE : S_SLOT;
            S_SLOT:  state_next = S_CHK;
            S_CHK:   state_next = (slot_rd_reg == '0) ? S_DONE : S_LEN;
            S_LEN:   state_next = S_CMP;
            S_CMP:
            begin
                if (mismatch)
                begin
                    state_next = probe_end ? S_DONE : S_SLOT;
                end
                else if (last_cmp)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:  if (done_go) state_next = do_new ? S_WRITE : S_BYTE;
            S_WRITE: if (last_wr) state_next = S_BYTE;
            default: state_next = S_BYTE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_BYTE;
            hash_reg     <= FNV_BASIS;
            hx_reg       <= '0;
            mul_pend_reg <= 1'b0;
            len_reg      <= '0;
            over_reg     <= 1'b0;
            pmatch_reg   <= 1'b1;
            mode_reg     <= 1'b0;
            label_reg    <= 1'b0;
            found_reg    <= 1'b0;
            empty_reg    <= 1'b0;
            clr_reg      <= '0;
            pos_reg      <= '0;
            visits_reg   <= '0;
            used_reg     <= '0;
            seen_reg     <= '0;
            sid_reg      <= '0;
            ci_reg       <= '0;
            rv_reg       <= 1'b0;
            res_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (!clr_reg[AW])
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (done_go)
            begin
                rv_reg <= 1'b1;
            end
            else if (rv_reg && res_ready)
            begin
                rv_reg <= 1'b0;
            end
            if (state_reg == S_CLEAR)
            begin
                hash_reg     <= FNV_BASIS;
                mul_pend_reg <= 1'b0;
            end
            else if (mul_pend_reg)
            begin
                hash_reg     <= prod;
                mul_pend_reg <= 1'b0;
            end
            unique case (state_reg)
                S_BYTE:
                begin
                    if (beat_take)
                    begin
                        hx_reg       <= hash_reg ^ {24'd0, beat.token_byte};
                        mul_pend_reg <= 1'b1;
                        mode_reg     <= beat.mode;
                        if ({1'b0, len_reg} < (LW+1)'(plen) && pb != beat.token_byte)
                        begin
                            pmatch_reg <= 1'b0;
                        end
                        if (len_reg < LW'(MAX_TOKEN_LEN))
                        begin
                            len_reg <= len_reg + 1'b1;
                        end
                        else
                        begin
                            over_reg <= 1'b1;
                        end
                    end
                end
                S_CLEAR:
                begin
                    // Hash product lands this cycle; start the probe from it.
                    pos_reg    <= prod[AW-1:0];
                    visits_reg <= '0;
                    found_reg  <= 1'b0;
                    empty_reg  <= 1'b0;
                    label_reg  <= pmatch_reg && ({1'b0, len_reg} >= (LW+1)'(plen));
                    pmatch_reg <= 1'b1;
                end
                S_SLOT: ;
                S_CHK:
                begin
                    if (slot_rd_reg == '0)
                    begin
                        empty_reg <= 1'b1;
                    end
                    else
                    begin
                        sid_reg <= AW'(slot_rd_reg - 1'b1);
                        ci_reg  <= '0;
                    end
                end
                S_LEN:
                begin
                    ci_reg <= ci_reg + 1'b1;
                end
                S_CMP:
                begin
                    if (mismatch)
                    begin
                        if (!probe_end)
                        begin
                            visits_reg <= visits_reg + 1'b1;
                            pos_reg    <= pos_inc;
                        end
                    end
                    else if (last_cmp)
                    begin
                        found_reg <= 1'b1;
                    end
                    else
                    begin
                        ci_reg <= ci_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (done_go)
                    begin
                        priority if (over_reg)
                        begin
                            res_reg <= '{12'd0, 1'b0, 1'b0, 32'd0, ST_TOO_LONG};
                        end
                        else if (found_reg)
                        begin
                            res_reg <= '{12'(sid_reg), 1'b0, typ_rd_reg,
                                         (mode_reg == MODE_INSERT) ? cnt_inc : cnt_rd_reg,
                                         ST_OK};
                        end
                        else if (mode_reg == MODE_LOOKUP)
                        begin
                            res_reg <= '{12'd0, 1'b0, 1'b0, 32'd0, ST_NOT_FOUND};
                        end
                        else if (do_new)
                        begin
                            res_reg <= '{12'(used_reg[AW-1:0]), 1'b1, label_reg, 32'd1, ST_OK};
                        end
                        else
                        begin
                            res_reg <= '{12'd0, 1'b0, 1'b0, 32'd0, ST_FULL};
                        end
                        over_reg <= 1'b0;
                        if (!over_reg && mode_reg == MODE_INSERT)
                        begin
                            seen_reg <= seen_reg + 40'd1;
                        end
                        if (do_new)
                        begin
                            sid_reg  <= used_reg[AW-1:0];
                            used_reg <= used_reg + 1'b1;
                            ci_reg   <= '0;
                        end
                        else
                        begin
                            len_reg <= '0;
                        end
                    end
                end
                S_WRITE:
                begin
                    ci_reg <= ci_reg + 1'b1;
                    if (last_wr)
                    begin
                        len_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg));
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res));
    a_no_take_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        beat_take |-> clr_reg[AW]);
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= (AW+1)'(TABLE_SIZE));
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(MAX_TOKEN_LEN));
endmodule

/* hdl/token_hash_count_table.sv */
// Top level of the token hash count table.
// Depends on thct_pkg, thct_if, thct_fifo and thct_back.
//
// Usage: byte beats arrive on the in channel (valid/ready); each beat carries one token
// byte, a last-byte mark and the insert/lookup mode. A result beat leaves on the out
// channel only for a last byte: entry id, new flag, label flag, count and status.
// TABLE_SIZE must be a power of two, not enforced; the start slot is the low hash bits.
// The front part queues beats in a four-deep queue that feeds the back part.
// The back part folds each byte in with an XOR and then the FNV multiply, and takes
// no new byte while the multiply is pending. After the last byte it does the final
// multiply in S_CLEAR, reads each probed slot in S_SLOT and S_CHK, and for an
// occupied slot reads its length in S_LEN and compares the bytes in S_CMP; a token
// that is too long skips the probe. The decision is made in S_DONE once the result
// register is free, and the result is valid after it. A new entry then stores its
// symbol in S_WRITE before the next byte is taken. Tokens are handled one at a time.
// After reset a sweep clears every slot of the slot memory while the back part
// takes no beat; the queue still accepts up to four beats. A stalled receiver holds
// the result register; the back part keeps hashing the next token and waits only
// when it has another result to post.
module token_hash_count_table
    import thct_pkg::*;
#(
    parameter int TABLE_SIZE    = 4096,
    parameter int MAX_TOKEN_LEN = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data,
    thct_in_if.sink     in_ch,
    thct_out_if.source  out_ch
);
    logic [63:0] prefix_reg;
    logic [3:0]  plen_reg;
    in_t         wr_beat, rd_beat;
    logic        full, empty, take;
    result_t     res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= '0;
            plen_reg   <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'b0)
            begin
                prefix_reg <= cfg_data;
            end
            else
            begin
                plen_reg <= cfg_data[3:0];
            end
        end
    end

    assign wr_beat     = '{in_ch.mode, in_ch.token_byte, in_ch.last_byte};
    assign in_ch.ready = !full;

    thct_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .wr_en(in_ch.valid && !full), .wr_data(wr_beat),
        .full(full), .rd_en(take), .rd_data(rd_beat), .empty(empty)
    );

    thct_back #(.TABLE_SIZE(TABLE_SIZE), .MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_back (
        .clk(clk), .rst_n(rst_n), .label_prefix(prefix_reg),
        .label_prefix_len(plen_reg), .beat_valid(!empty), .beat(rd_beat),
        .beat_take(take), .res_valid(out_ch.valid), .res(res), .res_ready(out_ch.ready)
    );

    assign out_ch.entry_id    = res.entry_id;
    assign out_ch.is_new      = res.is_new;
    assign out_ch.is_label    = res.is_label;
    assign out_ch.entry_count = res.entry_count;
    assign out_ch.status      = res.status;
endmodule
